// File: sv/vrp_pkg.sv
// vrp_pkg: types, constants and arithmetic helpers shared by the vertex rotate
// and project pipeline. No dependencies.
`default_nettype none
package vrp_pkg;

  localparam int unsigned CoordW  = 20;
  localparam int unsigned TrigW   = 16;
  localparam int unsigned RotW    = 21;
  localparam int unsigned ZoomW   = 20;
  localparam int unsigned CenterW = 13;
  localparam int unsigned FocalW  = 23;
  localparam int unsigned ScreenW = 16;
  localparam int unsigned FactorW = 18;
  localparam int unsigned DenW    = 24;
  localparam int unsigned NumW    = 40;
  localparam int unsigned RemW    = 42;
  localparam int unsigned ScaleW  = ZoomW + FactorW;
  localparam int unsigned ScaleLoW = 19;
  localparam int unsigned ScaleHiW = ScaleW - ScaleLoW;
  localparam int unsigned DivStages = FactorW + 1;
  localparam int unsigned CfgIdxW = 4;
  localparam int unsigned CfgDataW = 23;

  localparam logic [FactorW-1:0] FactorMax = '1;

  localparam logic [CfgIdxW-1:0] RegCosYaw   = 4'd0;
  localparam logic [CfgIdxW-1:0] RegSinYaw   = 4'd1;
  localparam logic [CfgIdxW-1:0] RegCosPitch = 4'd2;
  localparam logic [CfgIdxW-1:0] RegSinPitch = 4'd3;
  localparam logic [CfgIdxW-1:0] RegZoom     = 4'd4;
  localparam logic [CfgIdxW-1:0] RegCenterX  = 4'd5;
  localparam logic [CfgIdxW-1:0] RegCenterY  = 4'd6;
  localparam logic [CfgIdxW-1:0] RegFocal    = 4'd7;

  typedef struct packed {
    logic signed [RotW-1:0] x1;
    logic signed [RotW-1:0] y2;
    logic signed [RotW-1:0] z2;
    logic                   behind;
  } side_t;

  // Q1.14 product sum to rotated Q8.12: round half away, saturate.
  function automatic logic signed [RotW-1:0] rot_round(input logic signed [37:0] s);
    logic signed [37:0] b;
    logic signed [23:0] r;
    b = s + (s[37] ? 38'sd8191 : 38'sd8192);
    r = b[37:14];
    if (r > 24'sd1048575) begin
      return 21'sd1048575;
    end else if (r < -24'sd1048576) begin
      return -21'sd1048576;
    end
    return r[RotW-1:0];
  endfunction

  // Q.36 screen accumulator to pixels: round half away, saturate; bit 16 flags a hit.
  function automatic logic [ScreenW:0] scr_round(input logic signed [60:0] v);
    logic signed [60:0] b;
    logic signed [24:0] r;
    b = v + (v[60] ? 61'sh7_FFFF_FFFF : 61'sh8_0000_0000);
    r = b[60:36];
    if (r > 25'sd32767) begin
      return {1'b1, 16'h7FFF};
    end else if (r < -25'sd32768) begin
      return {1'b1, 16'h8000};
    end
    return {1'b0, r[ScreenW-1:0]};
  endfunction

endpackage
`default_nettype wire

// File: sv/vrp_if.sv
// vrp_if: valid/ready channel interfaces for vertices, pixels and configuration.
// Depends on vrp_pkg.
`default_nettype none
interface vrp_vtx_if;
  logic valid;
  logic ready;
  logic signed [vrp_pkg::CoordW-1:0] pos_x;
  logic signed [vrp_pkg::CoordW-1:0] pos_y;
  logic signed [vrp_pkg::CoordW-1:0] pos_z;
  modport source (output valid, pos_x, pos_y, pos_z, input ready);
  modport sink   (input valid, pos_x, pos_y, pos_z, output ready);
endinterface

interface vrp_pix_if;
  logic valid;
  logic ready;
  logic signed [vrp_pkg::ScreenW-1:0] screen_x;
  logic signed [vrp_pkg::ScreenW-1:0] screen_y;
  logic signed [vrp_pkg::RotW-1:0]    depth;
  logic                               behind_viewer;
  logic                               clipped;
  modport source (output valid, screen_x, screen_y, depth, behind_viewer, clipped,
                  input ready);
  modport sink   (input valid, screen_x, screen_y, depth, behind_viewer, clipped,
                  output ready);
endinterface

interface vrp_cfg_if;
  logic valid;
  logic ready;
  logic [vrp_pkg::CfgIdxW-1:0]  index;
  logic [vrp_pkg::CfgDataW-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

// File: sv/vrp_div.sv
// vrp_div: pipelined restoring divider for the perspective factor, one
// quotient bit per stage after a saturation check. Depends on vrp_pkg.
`default_nettype none
module vrp_div (
  input  wire logic                             clk_i,
  input  wire logic [vrp_pkg::DivStages-1:0]    en_i,
  input  wire logic [vrp_pkg::NumW-1:0]         num_i,
  input  wire logic [vrp_pkg::DenW-1:0]         den_i,
  input  wire vrp_pkg::side_t                   side_i,
  output logic [vrp_pkg::FactorW-1:0]           factor_o,
  output vrp_pkg::side_t                        side_o
);

  localparam int unsigned NS = vrp_pkg::DivStages;

  logic [vrp_pkg::RemW-1:0]    rem_q  [NS];
  logic [vrp_pkg::DenW-1:0]    den_q  [NS];
  logic [vrp_pkg::FactorW-1:0] quo_q  [NS];
  logic                        sat_q  [NS];
  vrp_pkg::side_t              side_q [NS];

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      rem_q[0]  <= vrp_pkg::RemW'(num_i);
      den_q[0]  <= den_i;
      quo_q[0]  <= '0;
      sat_q[0]  <= vrp_pkg::RemW'(num_i) >= (vrp_pkg::RemW'(den_i) << vrp_pkg::FactorW);
      side_q[0] <= side_i;
    end
  end

  for (genvar j = 1; j < NS; j++) begin : g_bit
    localparam int unsigned K = NS - 1 - j;
    logic [vrp_pkg::RemW-1:0] sub;
    logic                     take;
    assign sub  = vrp_pkg::RemW'(den_q[j-1]) << K;
    assign take = rem_q[j-1] >= sub;
    always_ff @(posedge clk_i) begin
      if (en_i[j]) begin
        rem_q[j]  <= take ? rem_q[j-1] - sub : rem_q[j-1];
        den_q[j]  <= den_q[j-1];
        quo_q[j]  <= quo_q[j-1] | (vrp_pkg::FactorW'(take) << K);
        sat_q[j]  <= sat_q[j-1];
        side_q[j] <= side_q[j-1];
      end
    end
  end

  assign factor_o = sat_q[NS-1] ? vrp_pkg::FactorMax : quo_q[NS-1];
  assign side_o   = side_q[NS-1];

endmodule
`default_nettype wire

// File: sv/vertex_rotate_project.sv
// vertex_rotate_project: yaw/pitch rotation and perspective projection pipeline.
// Depends on vrp_pkg, vrp_if and vrp_div.
//
//   channel  dir  payload                                          accept
//   in_i     in   pos_x, pos_y, pos_z                              valid & ready
//   out_o    out  screen_x, screen_y, depth, behind_viewer, clipped valid & ready
//   cfg_i    in   index, data                                      valid (ready is 1)
//
// One vertex per cycle when out_o does not stall; the divider has 19 stages.
// Each stage holds when it is full and the next stage cannot take it, so
// empty stages close up under a stall. Reset clears valid bits and sets the
// registers to their defaults; no clearing pass.
`default_nettype none
module vertex_rotate_project (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  vrp_vtx_if.sink   in_i,
  vrp_pix_if.source out_o,
  vrp_cfg_if.sink   cfg_i
);

  localparam int unsigned NS   = 10 + vrp_pkg::DivStages - 1;
  localparam int unsigned DivB = 5;
  localparam int unsigned DivE = DivB + vrp_pkg::DivStages - 1;

  logic signed [vrp_pkg::TrigW-1:0]   cos_yaw_q, sin_yaw_q, cos_pitch_q, sin_pitch_q;
  logic        [vrp_pkg::ZoomW-1:0]   zoom_q;
  logic signed [vrp_pkg::CenterW-1:0] center_x_q, center_y_q;
  logic        [vrp_pkg::FocalW-1:0]  focal_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cos_yaw_q   <= 16'sd16384;
      sin_yaw_q   <= '0;
      cos_pitch_q <= 16'sd16384;
      sin_pitch_q <= '0;
      zoom_q      <= 20'd256;
      center_x_q  <= '0;
      center_y_q  <= '0;
      focal_q     <= 23'd3686400;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        vrp_pkg::RegCosYaw:   cos_yaw_q   <= cfg_i.data[vrp_pkg::TrigW-1:0];
        vrp_pkg::RegSinYaw:   sin_yaw_q   <= cfg_i.data[vrp_pkg::TrigW-1:0];
        vrp_pkg::RegCosPitch: cos_pitch_q <= cfg_i.data[vrp_pkg::TrigW-1:0];
        vrp_pkg::RegSinPitch: sin_pitch_q <= cfg_i.data[vrp_pkg::TrigW-1:0];
        vrp_pkg::RegZoom:     zoom_q      <= cfg_i.data[vrp_pkg::ZoomW-1:0];
        vrp_pkg::RegCenterX:  center_x_q  <= cfg_i.data[vrp_pkg::CenterW-1:0];
        vrp_pkg::RegCenterY:  center_y_q  <= cfg_i.data[vrp_pkg::CenterW-1:0];
        vrp_pkg::RegFocal:    focal_q     <= cfg_i.data[vrp_pkg::FocalW-1:0];
        default: ;
      endcase
    end
  end

  logic [NS-1:0] v_q, v_d, load;

  always_comb begin
    load[NS-1] = !v_q[NS-1] || out_o.ready;
    for (int i = NS - 2; i >= 0; i--) begin
      load[i] = !v_q[i] || load[i+1];
    end
    v_d = {v_q[NS-2:0], in_i.valid};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      for (int i = 0; i < NS; i++) begin
        if (load[i]) begin
          v_q[i] <= v_d[i];
        end
      end
    end
  end

  assign in_i.ready = load[0];

  logic signed [35:0] s0_cx_q, s0_sz_q, s0_cz_q, s0_sx_q;
  logic signed [vrp_pkg::CoordW-1:0] s0_y_q;
  logic signed [vrp_pkg::RotW-1:0] s1_x1_q, s1_z1_q;
  logic signed [vrp_pkg::CoordW-1:0] s1_y_q;
  logic signed [36:0] s2_cy_q, s2_sz_q, s2_sy_q, s2_cz_q;
  logic signed [vrp_pkg::RotW-1:0] s2_x1_q;
  logic signed [vrp_pkg::RotW-1:0] s3_x1_q, s3_y2_q, s3_z2_q;
  logic [vrp_pkg::NumW-1:0] s4_num_q;
  logic [vrp_pkg::DenW-1:0] s4_den_q;
  vrp_pkg::side_t s4_side_q;

  logic signed [24:0] den_d;
  assign den_d = 25'($signed({1'b0, focal_q})) + 25'(s3_z2_q);

  always_ff @(posedge clk_i) begin
    if (load[0]) begin
      s0_cx_q <= cos_yaw_q * in_i.pos_x;
      s0_sz_q <= sin_yaw_q * in_i.pos_z;
      s0_cz_q <= cos_yaw_q * in_i.pos_z;
      s0_sx_q <= sin_yaw_q * in_i.pos_x;
      s0_y_q  <= in_i.pos_y;
    end
    if (load[1]) begin
      s1_x1_q <= vrp_pkg::rot_round(38'(s0_cx_q) + 38'(s0_sz_q));
      s1_z1_q <= vrp_pkg::rot_round(38'(s0_cz_q) - 38'(s0_sx_q));
      s1_y_q  <= s0_y_q;
    end
    if (load[2]) begin
      s2_cy_q <= cos_pitch_q * s1_y_q;
      s2_sz_q <= sin_pitch_q * s1_z1_q;
      s2_sy_q <= sin_pitch_q * s1_y_q;
      s2_cz_q <= cos_pitch_q * s1_z1_q;
      s2_x1_q <= s1_x1_q;
    end
    if (load[3]) begin
      s3_y2_q <= vrp_pkg::rot_round(38'(s2_cy_q) - 38'(s2_sz_q));
      s3_z2_q <= vrp_pkg::rot_round(38'(s2_sy_q) + 38'(s2_cz_q));
      s3_x1_q <= s2_x1_q;
    end
    if (load[4]) begin
      s4_den_q         <= den_d[vrp_pkg::DenW-1:0];
      s4_num_q         <= {1'b0, focal_q, 16'b0} + vrp_pkg::NumW'(den_d[vrp_pkg::DenW-1:1]);
      s4_side_q.x1     <= s3_x1_q;
      s4_side_q.y2     <= s3_y2_q;
      s4_side_q.z2     <= s3_z2_q;
      s4_side_q.behind <= den_d[24] || (den_d == '0);
    end
  end

  logic [vrp_pkg::FactorW-1:0] div_factor;
  vrp_pkg::side_t              div_side;

  vrp_div u_div (
    .clk_i    (clk_i),
    .en_i     (load[DivE:DivB]),
    .num_i    (s4_num_q),
    .den_i    (s4_den_q),
    .side_i   (s4_side_q),
    .factor_o (div_factor),
    .side_o   (div_side)
  );

  logic [vrp_pkg::ScaleW-1:0] s5_scale_q;
  vrp_pkg::side_t s5_side_q, s6_side_q, s7_side_q;
  logic signed [40:0] s6_xl_q, s6_xh_q, s6_yl_q, s6_yh_q;
  logic signed [60:0] s7_px_q, s7_py_q;
  logic signed [vrp_pkg::ScreenW-1:0] out_sx_q, out_sy_q;
  logic signed [vrp_pkg::RotW-1:0] out_depth_q;
  logic out_behind_q, out_clip_q;

  logic [vrp_pkg::ScreenW:0] rx, ry;
  assign rx = vrp_pkg::scr_round((61'(center_x_q) <<< 36) + s7_px_q);
  assign ry = vrp_pkg::scr_round((61'(center_y_q) <<< 36) - s7_py_q);

  always_ff @(posedge clk_i) begin
    if (load[DivE+1]) begin
      s5_scale_q <= zoom_q * div_factor;
      s5_side_q  <= div_side;
    end
    if (load[DivE+2]) begin
      s6_xl_q   <= s5_side_q.x1 * $signed({1'b0, s5_scale_q[vrp_pkg::ScaleLoW-1:0]});
      s6_xh_q   <= s5_side_q.x1 * $signed({1'b0, s5_scale_q[vrp_pkg::ScaleW-1:vrp_pkg::ScaleLoW]});
      s6_yl_q   <= s5_side_q.y2 * $signed({1'b0, s5_scale_q[vrp_pkg::ScaleLoW-1:0]});
      s6_yh_q   <= s5_side_q.y2 * $signed({1'b0, s5_scale_q[vrp_pkg::ScaleW-1:vrp_pkg::ScaleLoW]});
      s6_side_q <= s5_side_q;
    end
    if (load[DivE+3]) begin
      s7_px_q   <= (61'(s6_xh_q) <<< vrp_pkg::ScaleLoW) + 61'(s6_xl_q);
      s7_py_q   <= (61'(s6_yh_q) <<< vrp_pkg::ScaleLoW) + 61'(s6_yl_q);
      s7_side_q <= s6_side_q;
    end
    if (load[NS-1]) begin
      out_sx_q     <= s7_side_q.behind ? '0 : rx[vrp_pkg::ScreenW-1:0];
      out_sy_q     <= s7_side_q.behind ? '0 : ry[vrp_pkg::ScreenW-1:0];
      out_clip_q   <= !s7_side_q.behind && (rx[vrp_pkg::ScreenW] || ry[vrp_pkg::ScreenW]);
      out_depth_q  <= s7_side_q.z2;
      out_behind_q <= s7_side_q.behind;
    end
  end

  assign out_o.valid         = v_q[NS-1];
  assign out_o.screen_x      = out_sx_q;
  assign out_o.screen_y      = out_sy_q;
  assign out_o.depth         = out_depth_q;
  assign out_o.behind_viewer = out_behind_q;
  assign out_o.clipped       = out_clip_q;

  a_empty_tail_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !v_q[NS-1] |-> in_i.ready) else $error("input held off with empty output stage");

  a_no_internal_loss: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[DivB] && !load[DivB] |=> v_q[DivB]) else $error("stalled divider entry lost");

  a_behind_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.behind_viewer |->
      out_o.screen_x == '0 && out_o.screen_y == '0 && !out_o.clipped)
    else $error("behind-viewer result carries screen data");

  a_take_moves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.valid && in_i.ready |=> v_q[0]) else $error("accepted vertex not captured");

endmodule
`default_nettype wire
